/* rtl/ils_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the indexed list store.
// No dependencies; every other file imports this package.
package ils_pkg;

  localparam int CAPACITY_DEF  = 64;
  localparam int WORD_BITS_DEF = 32;

  localparam int CMD_W    = 3;
  localparam int POS_W    = 7;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD_FRONT    = 3'd0,
    CMD_ADD_REAR     = 3'd1,
    CMD_REMOVE_FRONT = 3'd2,
    CMD_REMOVE_REAR  = 3'd3,
    CMD_INSERT_AT    = 3'd4,
    CMD_REMOVE_AT    = 3'd5
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_RANGE     = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // Broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    SHIFT_HOLD,
    SHIFT_INSERT,
    SHIFT_REMOVE
  } shift_op_e;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [POS_W-1:0]   position;
    logic [VALUE_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  removed_value;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  entry_count;
    logic                is_empty;
  } out_word_t;

endpackage

/* rtl/ils_cell.sv */
`timescale 1ns / 1ps
// One storage cell of the list chain: holds one entry and shifts with its neighbors.
// Depends on ils_pkg for the shift operation type.
module ils_cell import ils_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int IDX_W     = 6,
  parameter int INDEX     = 0
) (
  input  logic                 clk_i,
  input  shift_op_e            op_i,
  input  logic [IDX_W-1:0]     idx_i,
  input  logic [WORD_BITS-1:0] new_word_i,
  input  logic [WORD_BITS-1:0] left_word_i,
  input  logic [WORD_BITS-1:0] right_word_i,
  output logic [WORD_BITS-1:0] word_o,
  output logic [WORD_BITS-1:0] hit_word_o
);

  logic [WORD_BITS-1:0] word_q, word_d;
  logic at_idx, past_idx;

  assign at_idx   = (idx_i == IDX_W'(INDEX));
  assign past_idx = (IDX_W'(INDEX) > idx_i);

  always_comb begin
    word_d = word_q;
    unique case (op_i)
      SHIFT_INSERT: begin
        if (at_idx) begin
          word_d = new_word_i;
        end else if (past_idx) begin
          word_d = left_word_i;
        end
      end
      SHIFT_REMOVE: begin
        if (at_idx || past_idx) begin
          word_d = right_word_i;
        end
      end
      default: word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o     = word_q;
  // Drive the stored word onto the removal bus only when this cell is the one leaving.
  assign hit_word_o = (op_i == SHIFT_REMOVE && at_idx) ? word_q : '0;

endmodule

/* rtl/ils_ctrl.sv */
`timescale 1ns / 1ps
// Command decode, bounds checks and entry counter of the list store.
// Depends on ils_pkg for command, status and shift codes.
module ils_ctrl import ils_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int IDX_W    = $clog2(CAPACITY),
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [CMD_W-1:0]   command_i,
  input  logic [POS_W-1:0]   position_i,
  output shift_op_e          op_o,
  output logic [IDX_W-1:0]   idx_o,
  output status_e            status_o,
  output logic [COUNT_W-1:0] count_o,
  output logic               empty_o
);

  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  logic [CNT_W-1:0] count_q, count_d;
  logic [CMP_W-1:0] pos_x, cnt_x, cnt_next_x;
  logic             full, empty;
  shift_op_e        op;

  assign pos_x = CMP_W'(position_i);
  assign cnt_x = CMP_W'(count_q);
  assign full  = (count_q == CNT_W'(CAPACITY));
  assign empty = (count_q == '0);

  always_comb begin
    op       = SHIFT_HOLD;
    idx_o    = '0;
    status_o = ST_OK;
    unique case (cmd_e'(command_i))
      CMD_ADD_FRONT: begin
        if (full) status_o = ST_FULL;
        else op = SHIFT_INSERT;
      end
      CMD_ADD_REAR: begin
        idx_o = IDX_W'(count_q);
        if (full) status_o = ST_FULL;
        else op = SHIFT_INSERT;
      end
      CMD_REMOVE_FRONT: begin
        if (empty) status_o = ST_UNDERFLOW;
        else op = SHIFT_REMOVE;
      end
      CMD_REMOVE_REAR: begin
        idx_o = IDX_W'(count_q - CNT_W'(1));
        if (empty) status_o = ST_UNDERFLOW;
        else op = SHIFT_REMOVE;
      end
      CMD_INSERT_AT: begin
        idx_o = IDX_W'(pos_x - CMP_W'(1));
        // Range is checked ahead of capacity.
        priority if (pos_x == '0 || pos_x > cnt_x + CMP_W'(1)) status_o = ST_RANGE;
        else if (full) status_o = ST_FULL;
        else op = SHIFT_INSERT;
      end
      CMD_REMOVE_AT: begin
        idx_o = IDX_W'(pos_x - CMP_W'(1));
        if (pos_x == '0 || pos_x > cnt_x) status_o = ST_RANGE;
        else op = SHIFT_REMOVE;
      end
      default: op = SHIFT_HOLD;  // unused codes leave the list alone
    endcase
  end

  assign op_o = accept_i ? op : SHIFT_HOLD;

  always_comb begin
    unique case (op)
      SHIFT_INSERT: count_d = count_q + CNT_W'(1);
      SHIFT_REMOVE: count_d = count_q - CNT_W'(1);
      default:      count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept_i) begin
      count_q <= count_d;
    end
  end

  assign cnt_next_x = CMP_W'(count_d);
  assign count_o    = cnt_next_x[COUNT_W-1:0];
  assign empty_o    = (count_d == '0);

endmodule

/* rtl/indexed_list_store_unit.sv */
`timescale 1ns / 1ps
// Indexed list store: a bounded ordered list of words with deque and positional access.
// Depends on ils_pkg, ils_ctrl and ils_cell.
//
// The list is a chain of CAPACITY cells, position 1 in cell 0. Every command is
// decoded combinationally: the controller checks the count and position and
// broadcasts one shift operation and a cell index, and every cell picks its next
// word from itself, the new word or a neighbor in the same clock edge, so an insert
// or a remove at any position completes in that edge. The removed word is collected
// from the chain by an OR across the cells. Each command returns exactly one result
// word in the cycle after it is accepted, held in an output register; a new command
// is taken in every cycle in which that register is empty or being drained, so the
// sustained rate is one command per cycle when the result side does not stall.
// Status codes: ok, underflow (remove from an empty list), out of range (bad
// position, checked before fullness) and full (the command is refused). Unused
// command codes return ok and change nothing. Entries beyond the count are never
// read, so the cells need no reset.
module indexed_list_store_unit import ils_pkg::*; #(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic               accept;
  logic               out_valid_q;
  out_word_t          out_word_q;
  shift_op_e          op;
  logic [IDX_W-1:0]   idx;
  status_e            status;
  logic [COUNT_W-1:0] count_next;
  logic               empty_next;

  logic [WORD_BITS-1:0] new_word;
  logic [WORD_BITS-1:0] removed_word;
  logic [VALUE_W-1:0]   removed_value;
  logic [WORD_BITS-1:0] cell_word [CAPACITY];
  logic [WORD_BITS-1:0] hit_word  [CAPACITY];

  // Stall only while a result waits and the far side is not taking it.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Fit the incoming value to the stored word width and the removed word back to 32 bits.
  generate
    if (WORD_BITS >= VALUE_W) begin : g_wide
      assign new_word      = WORD_BITS'(in_word_i.value);
      assign removed_value = removed_word[VALUE_W-1:0];
    end else begin : g_narrow
      assign new_word      = in_word_i.value[WORD_BITS-1:0];
      assign removed_value = VALUE_W'(removed_word);
    end
  endgenerate

  ils_ctrl #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .command_i  (in_word_i.command),
    .position_i (in_word_i.position),
    .op_o       (op),
    .idx_o      (idx),
    .status_o   (status),
    .count_o    (count_next),
    .empty_o    (empty_next)
  );

  // Chain of cells; the ends see zero from outside the list.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_BITS-1:0] left_word, right_word;
    if (i == 0) begin : g_first
      assign left_word = '0;
    end else begin : g_mid_l
      assign left_word = cell_word[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_word = '0;
    end else begin : g_mid_r
      assign right_word = cell_word[i+1];
    end

    ils_cell #(
      .WORD_BITS (WORD_BITS),
      .IDX_W     (IDX_W),
      .INDEX     (i)
    ) u_cell (
      .clk_i        (clk_i),
      .op_i         (op),
      .idx_i        (idx),
      .new_word_i   (new_word),
      .left_word_i  (left_word),
      .right_word_i (right_word),
      .word_o       (cell_word[i]),
      .hit_word_o   (hit_word[i])
    );
  end

  // At most one cell drives a nonzero word, so an OR gathers the removed entry.
  always_comb begin
    removed_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      removed_word = removed_word | hit_word[i];
    end
  end

  // Output register: load on accept, drop the valid once the word is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_word_q.removed_value <= removed_value;
      out_word_q.status        <= status;
      out_word_q.entry_count   <= count_next;
      out_word_q.is_empty      <= empty_next;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
